// ===== rtl/cde_pkg.sv =====
// Package for the complex density entropy unit: widths, constants, control structs.
// No dependencies.
package cde_pkg;
    localparam int MAX_CELLS   = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_CELLS);
    localparam int CNT_W       = $clog2(MAX_CELLS + 1);
    localparam int MAG_W       = 2 * SAMPLE_BITS;
    localparam int TOT_W       = 44;
    localparam int ACC_W       = 48;
    localparam int LOG_STEPS   = 30;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef struct packed {
        logic        start;
        logic [31:0] share;
    } t_term_req;

    typedef struct packed {
        logic        done;
        logic [47:0] term;
    } t_term_rsp;
endpackage

// ===== rtl/cde_term.sv =====
// Term unit: -rho*ln(rho) in Q.30 nats for a Q0.32 share, one squaring per cycle.
// Depends on cde_pkg.
module cde_term (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cde_pkg::t_term_req i_req,
    output cde_pkg::t_term_rsp o_rsp
);
    import cde_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_NORM = 3'd1, S_SQ = 3'd2,
                           S_M1 = 3'd3, S_M2 = 3'd4, S_M3 = 3'd5;

    logic [2:0]  r_st;
    logic [31:0] r_q;
    logic [32:0] r_m;
    logic [5:0]  r_p;
    logic [4:0]  r_i;
    logic [29:0] r_frac;
    logic [63:0] r_prod;
    logic [47:0] r_h;
    logic [47:0] r_term;
    logic        r_done;
    logic [65:0] sq;
    logic [35:0] nl2;

    assign sq  = {33'd0, r_m} * {33'd0, r_m};
    // -log2 of the share; reaches 32.0 for the smallest share
    assign nl2 = {(6'd32 - r_p), 30'd0} - {6'd0, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_req.start) begin
                    r_q    <= i_req.share;
                    r_m    <= {1'b0, i_req.share};
                    r_p    <= 6'd31;
                    r_frac <= '0;
                    r_i    <= '0;
                    r_st   <= S_NORM;
                end
                S_NORM: begin
                    // shift left until bit 31 set, up to 8 per cycle
                    if (r_m[31]) r_st <= S_SQ;
                    else if (r_m[31:24] == 8'd0 && r_p >= 6'd8) begin
                        r_m <= {r_m[32:0] << 8}; r_p <= r_p - 6'd8;
                    end else begin
                        r_m <= r_m << 1; r_p <= r_p - 6'd1;
                    end
                end
                S_SQ: begin
                    logic [34:0] m2;
                    m2 = sq[65:31];
                    if (m2[34:32] != 3'd0) begin
                        r_m <= m2[33:1]; r_frac <= {r_frac[28:0], 1'b1};
                    end else begin
                        r_m <= m2[32:0]; r_frac <= {r_frac[28:0], 1'b0};
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(LOG_STEPS - 1)) r_st <= S_M1;
                end
                S_M1: begin
                    r_prod <= {32'd0, r_q} * {28'd0, nl2};
                    r_st   <= S_M2;
                end
                S_M2: begin
                    r_h  <= {16'd0, r_prod[63:32]};
                    r_st <= S_M3;
                end
                S_M3: begin
                    logic [79:0] t;
                    t = {32'd0, r_h} * {48'd0, LN2_Q32};
                    r_term <= t[79:32];
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.term = r_term;
endmodule

// ===== rtl/cde_div.sv =====
// Restoring divider: floor(mag * 2^32 / total), one quotient bit per cycle.
// Depends on cde_pkg.
module cde_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cde_pkg::MAG_W-1:0] i_mag,
    input  logic [cde_pkg::TOT_W-1:0] i_total,
    output logic                     o_done,
    output logic [31:0]              o_share
);
    import cde_pkg::*;

    logic             r_busy;
    logic [5:0]       r_n;
    logic [TOT_W:0]   r_rem;
    logic [31:0]      r_q;
    logic [TOT_W-1:0] r_d;
    logic             r_done;
    logic [TOT_W:0]   sh;

    assign sh = {r_rem[TOT_W-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= {{(TOT_W + 1 - MAG_W){1'b0}}, i_mag};
                r_d    <= i_total;
                r_n    <= '0;
            end else if (r_busy) begin
                if (sh >= {1'b0, r_d}) begin
                    r_rem <= sh - {1'b0, r_d}; r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= sh; r_q <= {r_q[30:0], 1'b0};
                end
                r_n <= r_n + 6'd1;
                if (r_n == 6'd31) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_share = r_q;
endmodule

// ===== rtl/complex_density_entropy_unit.sv =====
// Complex density entropy unit: magnitudes go to a 4096-entry store on load; the last
// beat starts a pass over the stored cells: a cell below the total is divided by it,
// and the log term is taken for a nonzero share above the floor. Load beats are taken
// only in the load state; a zero total yields its result without a pass. The next frame
// may load while a result waits in the output register.
// Reset (synchronous, active low) clears total, count, accumulator and floor;
module complex_density_entropy_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_real[15:0], sample_imag[31:16]
    input  logic        s_axis_tlast,   // frame_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // entropy_value[31:0]
    output logic        m_axis_tuser,   // zero_total
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cde_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0, S_RD = 3'd1, S_CHK = 3'd2, S_DIV = 3'd3,
                           S_TERM = 3'd4, S_OUT = 3'd5;
    localparam logic [1:0] A_FLOOR = 2'd0;

    logic [MAG_W-1:0] mem [MAX_CELLS];
    logic [MAG_W-1:0] r_rd;
    logic [2:0]       r_st;
    logic [TOT_W-1:0] r_tot;
    logic [CNT_W-1:0] r_cnt, r_idx;
    logic [ACC_W-1:0] r_acc;
    logic [31:0]      r_floor, r_res, r_odata;
    logic             r_zero, r_ouser, r_ov, r_ds;
    t_term_req        treq;
    t_term_rsp        trsp;
    logic             dv_done;
    logic [31:0]      dv_q;
    logic [SAMPLE_BITS-1:0] ar, ai;
    logic [MAG_W-1:0] mag;
    logic             acc_in;
    logic [ACC_W:0]   sum;

    assign pready = 1'b1;
    assign prdata = (paddr == A_FLOOR) ? r_floor : 32'd0;
    assign ar  = s_axis_tdata[SAMPLE_BITS-1] ? (~s_axis_tdata[SAMPLE_BITS-1:0] + 1'b1)
                                             : s_axis_tdata[SAMPLE_BITS-1:0];
    assign ai  = s_axis_tdata[16+SAMPLE_BITS-1] ? (~s_axis_tdata[16+SAMPLE_BITS-1:16] + 1'b1)
                                                : s_axis_tdata[16+SAMPLE_BITS-1:16];
    assign mag = {{SAMPLE_BITS{1'b0}}, ar} * {{SAMPLE_BITS{1'b0}}, ar}
               + {{SAMPLE_BITS{1'b0}}, ai} * {{SAMPLE_BITS{1'b0}}, ai};
    assign s_axis_tready = (r_st == S_LOAD);
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign sum = {1'b0, r_acc} + {1'b0, trsp.term};
    assign treq.start = dv_done && dv_q != 32'd0 && dv_q > r_floor;
    assign treq.share = dv_q;

    always_ff @(posedge i_clk) begin
        if (acc_in && !r_ov) mem[r_cnt[ADDR_W-1:0]] <= mag;
        r_rd <= mem[r_idx[ADDR_W-1:0]];
    end

    cde_div u_div (.i_clk, .i_rst_n, .i_start(r_ds), .i_mag(r_rd), .i_total(r_tot),
                   .o_done(dv_done), .o_share(dv_q));
    cde_term u_term (.i_clk, .i_rst_n, .i_req(treq), .o_rsp(trsp));

    assign r_ov = (r_cnt == CNT_W'(MAX_CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_tot <= '0; r_cnt <= '0; r_acc <= '0; r_floor <= '0;
            r_idx <= '0; r_ds <= 1'b0; m_axis_tvalid <= 1'b0;
        end else begin
            r_ds <= 1'b0;
            if (psel && penable && pwrite && paddr == A_FLOOR) r_floor <= pwdata;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_st)
                S_LOAD: if (acc_in) begin
                    logic [TOT_W-1:0] nt;
                    nt = r_ov ? r_tot : r_tot + TOT_W'(mag);
                    r_tot <= nt;
                    if (!r_ov) r_cnt <= r_cnt + 1'b1;
                    r_idx <= '0; r_acc <= '0;
                    if (s_axis_tlast) begin
                        if (nt == '0) begin
                            r_res <= '0; r_zero <= 1'b1; r_st <= S_OUT;
                        end else r_st <= S_RD;
                    end
                end
                S_RD: begin
                    // read issued at r_idx; data valid next cycle
                    if (r_idx == r_cnt) begin
                        r_res <= (r_acc[ACC_W-1:34] != '0) ? 32'hFFFFFFFF : r_acc[33:2];
                        r_zero <= 1'b0; r_st <= S_OUT;
                    end else r_st <= S_CHK;
                end
                S_CHK: begin
                    r_idx <= r_idx + 1'b1;
                    if (TOT_W'(r_rd) >= r_tot) r_st <= S_RD;
                    else begin r_ds <= 1'b1; r_st <= S_DIV; end
                end
                S_DIV: if (dv_done) r_st <= treq.start ? S_TERM : S_RD;
                S_TERM: if (trsp.done) begin
                    r_acc <= sum[ACC_W] ? ACC_MAX : (sum[ACC_W-1:0]);
                    r_st  <= S_RD;
                end
                S_OUT: if (!m_axis_tvalid) begin
                    // hand the result to the output register and reopen the input
                    m_axis_tvalid <= 1'b1; r_odata <= r_res; r_ouser <= r_zero;
                    r_tot <= '0; r_cnt <= '0; r_acc <= '0;
                    r_st <= S_LOAD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;
endmodule
